FILE: rtl/core/integer_to_ascii_formatter_macros.svh
// Assertion macros used by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define I2A_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("formatter check failed in the same cycle");

// Next-cycle implication, disabled while reset is held.
`define I2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("formatter check failed one cycle later");

`endif

FILE: rtl/core/i2a_pkg.sv
package i2a_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int MAG_W   = 32;
    localparam int RADIX_W = 2;
    localparam int FW_W    = 7;
    localparam int CHAR_W  = 7;

    // Radix selector codes.
    localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd1;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd2;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd3;

    // Operations of the shared digit unit.
    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_DABBLE = 3'd2;
    localparam logic [2:0] OP_NORM   = 3'd3;
    localparam logic [2:0] OP_NEXT   = 3'd4;

    // ASCII characters.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [3:0]        DIGIT_MAX = 4'd9;
    localparam logic [CHAR_W-1:0] DIGIT_TEN = 7'd10;

    typedef struct packed {
        logic [2:0]         op;
        logic [RADIX_W-1:0] radix;
    } digit_cmd_t;

    typedef struct packed {
        logic [3:0] top_digit;
        logic       norm_done;
    } digit_stat_t;

    typedef struct packed {
        logic            negative;
        logic [FW_W-1:0] field_width;
        logic            left_adjust;
        logic            zero_pad;
        logic            upper_case;
    } opts_t;

    typedef struct packed {
        logic plan;
        logic run;
    } emit_ctl_t;

    typedef struct packed {
        logic take_digit;
        logic done;
    } emit_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {3'b000, d};
        if (d <= DIGIT_MAX) begin
            digit_char = CH_ZERO + d_ext;
        end else if (upper) begin
            digit_char = CH_UA + d_ext - DIGIT_TEN;
        end else begin
            digit_char = CH_LA + d_ext - DIGIT_TEN;
        end
    endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// Flow: an accepted item is loaded into the digit unit; decimal items first run the
// shift-and-add-3 conversion, then every radix drops leading zero digits one per cycle,
// the field layout is planned, and the characters are emitted.
// Throughput: one character per cycle once emission starts, while m_tready is high;
// the next item is accepted after its last character.
// Reset: aresetn is synchronous and active low; it returns the sequencer to idle and drops m_tvalid.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: magnitude [31:0], field_width [38:32], zero fill [39].
    input  logic [39:0] s_tdata,
    // s_tuser, lowest bit up: radix_sel [1:0], negative [2], left_adjust [3], zero_pad [4],
    // upper_case [5].
    input  logic [5:0]  s_tuser,
    // Result words, one character each.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: char_out [6:0], zero fill [7].
    output logic [7:0]  m_tdata,
    // m_tlast carries last_char.
    output logic        m_tlast
);

    // The block runs one item at a time through a small sequencer. A single shift unit
    // holds the digits: for decimal it first runs the shift-and-add-3 conversion, then for
    // every radix it drops leading zero digits one per cycle, and finally it shifts one
    // digit out each time the emitter sends a digit character.

    localparam int NDW = $clog2(VALUE_BITS + 1);
    localparam int CW  = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_NORM = 3'd2;
    localparam logic [2:0] ST_PLAN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    opts_t                 opts_reg;
    logic                  accept;
    logic [RADIX_W-1:0]    radix_in;
    logic [VALUE_BITS-1:0] val_in;
    digit_cmd_t            dcmd;
    digit_stat_t           dstat;
    logic [NDW-1:0]        ndig;
    emit_ctl_t             ectl;
    emit_stat_t            estat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign radix_in = s_tuser[1:0];
    // Only the low VALUE_BITS bits of the magnitude take part.
    assign val_in   = VALUE_BITS'({{VALUE_BITS{1'b0}}, s_tdata[MAG_W-1:0]});

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcmd.op    = OP_HOLD;
        dcmd.radix = radix_in;
        ectl.plan  = 1'b0;
        ectl.run   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dcmd.op    = OP_LOAD;
                    cnt_next   = '0;
                    state_next = (radix_in == RADIX_DEC) ? ST_CONV : ST_NORM;
                end
            end
            ST_CONV: begin
                // One value bit enters the BCD register per cycle, most significant first.
                dcmd.op  = OP_DABBLE;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // Strip leading zero digits, keeping at least one digit.
                if (dstat.norm_done) begin
                    state_next = ST_PLAN;
                end else begin
                    dcmd.op = OP_NORM;
                end
            end
            ST_PLAN: begin
                ectl.plan  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                ectl.run = 1'b1;
                if (estat.take_digit) begin
                    dcmd.op = OP_NEXT;
                end
                if (estat.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Field options are held for the whole item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            opts_reg.negative    <= s_tuser[2];
            opts_reg.field_width <= s_tdata[38:32];
            opts_reg.left_adjust <= s_tuser[3];
            opts_reg.zero_pad    <= s_tuser[4];
            opts_reg.upper_case  <= s_tuser[5];
        end
    end

    i2a_digit_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit (
        .aclk   (aclk),
        .cmd    (dcmd),
        .val_in (val_in),
        .stat   (dstat),
        .ndig   (ndig)
    );

    i2a_emitter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ectl),
        .opts      (opts_reg),
        .ndig      (ndig),
        .top_digit (dstat.top_digit),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .stat      (estat)
    );

    // An accepted item keeps the block busy in the following cycle.
    `I2A_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    // Digits are consumed only while characters are being emitted.
    `I2A_ASSERT_NOW(a_take_in_emit, aclk, aresetn, estat.take_digit, state_reg == ST_EMIT)
    // Leading zero removal never leaves the item without a digit.
    `I2A_ASSERT_NOW(a_digit_left, aclk, aresetn,
        state_reg == ST_NORM || state_reg == ST_PLAN || state_reg == ST_EMIT, ndig != '0)

endmodule

FILE: rtl/core/i2a_digit_unit.sv
module i2a_digit_unit
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  digit_cmd_t                      cmd,
    input  logic [VALUE_BITS-1:0]           val_in,
    output digit_stat_t                     stat,
    output logic [$clog2(VALUE_BITS+1)-1:0] ndig
);

    localparam int NDW        = $clog2(VALUE_BITS + 1);
    localparam int DEC_DIGITS = VALUE_BITS * 30103 / 100000 + 1;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int WR         = 4 * DEC_DIGITS;
    localparam int BIN_SHIFT  = WR - VALUE_BITS;
    localparam int OCT_SHIFT  = WR - 3 * OCT_DIGITS;
    localparam int HEX_SHIFT  = WR - 4 * HEX_DIGITS;
    localparam logic [3:0] BCD_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ   = 4'd3;

    // Digits sit top-aligned in work_reg; the most significant one is read at the top.
    logic [WR-1:0]         work_reg, work_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [NDW-1:0]        ndig_reg, ndig_next;
    logic [WR-1:0]         bcd_adj;
    logic [WR-1:0]         work_step;
    logic [3:0]            top_digit;

    always_comb begin
        logic [3:0] nib;
        nib = '0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            nib = work_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= BCD_LIMIT) ? nib + BCD_ADJ : nib;
        end
    end

    always_comb begin
        case (radix_reg)
            RADIX_BIN: begin
                work_step = work_reg << 1;
                top_digit = {3'b000, work_reg[WR-1]};
            end
            RADIX_OCT: begin
                work_step = work_reg << 3;
                top_digit = {1'b0, work_reg[WR-1 -: 3]};
            end
            default: begin
                work_step = work_reg << 4;
                top_digit = work_reg[WR-1 -: 4];
            end
        endcase
    end

    always_comb begin
        work_next  = work_reg;
        val_next   = val_reg;
        radix_next = radix_reg;
        ndig_next  = ndig_reg;
        case (cmd.op)
            OP_LOAD: begin
                radix_next = cmd.radix;
                val_next   = val_in;
                case (cmd.radix)
                    RADIX_BIN: begin
                        work_next = WR'(val_in) << BIN_SHIFT;
                        ndig_next = NDW'(VALUE_BITS);
                    end
                    RADIX_OCT: begin
                        work_next = WR'(val_in) << OCT_SHIFT;
                        ndig_next = NDW'(OCT_DIGITS);
                    end
                    RADIX_HEX: begin
                        work_next = WR'(val_in) << HEX_SHIFT;
                        ndig_next = NDW'(HEX_DIGITS);
                    end
                    default: begin
                        work_next = '0;
                        ndig_next = NDW'(DEC_DIGITS);
                    end
                endcase
            end
            OP_DABBLE: begin
                work_next = {bcd_adj[WR-2:0], val_reg[VALUE_BITS-1]};
                val_next  = val_reg << 1;
            end
            OP_NORM: begin
                work_next = work_step;
                ndig_next = ndig_reg - NDW'(1);
            end
            OP_NEXT: begin
                work_next = work_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        val_reg   <= val_next;
        radix_reg <= radix_next;
        ndig_reg  <= ndig_next;
    end

    assign stat.top_digit = top_digit;
    assign stat.norm_done = (top_digit != 4'd0) || (ndig_reg == NDW'(1));
    assign ndig           = ndig_reg;

endmodule

FILE: rtl/core/i2a_emitter.sv
module i2a_emitter
    import i2a_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  emit_ctl_t                       ctl,
    input  opts_t                           opts,
    input  logic [$clog2(VALUE_BITS+1)-1:0] ndig,
    input  logic [3:0]                      top_digit,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast,
    output emit_stat_t                      stat
);

    localparam int CNTW_A = $clog2(MAX_WIDTH + VALUE_BITS + 2);
    localparam int CNTW   = (CNTW_A > FW_W) ? CNTW_A : FW_W;

    logic [CNTW-1:0]   actual, wclamp, len, total;
    logic [CNTW-1:0]   actual_reg, pad_reg, last_pos_reg, pos_reg;
    logic              m_tvalid_reg, last_reg;
    logic [CHAR_W-1:0] char_reg, ch;
    logic              is_digit, fire, at_last;
    logic [CNTW-1:0]   neg_ext;

    // Field layout, worked out once per item.
    always_comb begin
        actual = CNTW'(ndig) + CNTW'(opts.negative);
        wclamp = (CNTW'(opts.field_width) > CNTW'(MAX_WIDTH)) ? CNTW'(MAX_WIDTH)
                                                               : CNTW'(opts.field_width);
        len    = (wclamp > actual) ? wclamp : actual;
        total  = (len > CNTW'(MAX_WIDTH)) ? CNTW'(MAX_WIDTH) : len;
    end

    assign neg_ext = CNTW'(opts.negative);

    always_comb begin
        is_digit = 1'b0;
        ch       = CH_SPACE;
        if (opts.left_adjust) begin
            if (opts.negative && pos_reg == '0) begin
                ch = CH_MINUS;
            end else if (pos_reg < actual_reg) begin
                is_digit = 1'b1;
            end
        end else if (opts.zero_pad) begin
            if (opts.negative && pos_reg == '0) begin
                ch = CH_MINUS;
            end else if (pos_reg < pad_reg + neg_ext) begin
                ch = CH_ZERO;
            end else begin
                is_digit = 1'b1;
            end
        end else begin
            if (pos_reg < pad_reg) begin
                ch = CH_SPACE;
            end else if (opts.negative && pos_reg == pad_reg) begin
                ch = CH_MINUS;
            end else begin
                is_digit = 1'b1;
            end
        end
        if (is_digit) begin
            ch = digit_char(top_digit, opts.upper_case);
        end
    end

    assign fire    = ctl.run && (!m_tvalid_reg || m_tready);
    assign at_last = (pos_reg == last_pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pos_reg      <= '0;
        end else begin
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (ctl.plan) begin
                pos_reg <= '0;
            end else if (fire) begin
                pos_reg <= pos_reg + CNTW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.plan) begin
            actual_reg   <= actual;
            pad_reg      <= len - actual;
            last_pos_reg <= total - CNTW'(1);
        end
        if (fire) begin
            char_reg <= ch;
            last_reg <= at_last;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = {1'b0, char_reg};
    assign m_tlast         = last_reg;
    assign stat.take_digit = fire && is_digit;
    assign stat.done       = fire && at_last;

endmodule
